@@ design/ckx_pkg.sv @@
// Shared types, constants and base decoding for the canonical k-mer extractor.
package ckx_pkg;

	localparam int CHAR_W  = 8;
	localparam int GROUP_W = 32;
	localparam int KEY_W   = 64;
	localparam int KLEN_W  = 6;
	localparam int DATA_W  = 32;
	localparam int ADDR_W  = 3;

	localparam logic [CHAR_W-1:0] CHAR_A = 8'h41;
	localparam logic [CHAR_W-1:0] CHAR_C = 8'h43;
	localparam logic [CHAR_W-1:0] CHAR_G = 8'h47;
	localparam logic [CHAR_W-1:0] CHAR_T = 8'h54;

	localparam logic [KLEN_W-1:0] KLEN_RESET = 6'd21;

	typedef enum logic {
		REG_KMER_LENGTH   = 1'b0,
		REG_CANONICAL_MODE = 1'b1
	} reg_idx_t;

	typedef enum logic [1:0] {
		CODE_A = 2'd0,
		CODE_C = 2'd1,
		CODE_G = 2'd2,
		CODE_T = 2'd3
	} base_code_t;

	typedef struct packed {
		logic ok;
		base_code_t code;
	} base_dec_t;

	typedef struct packed {
		logic load;
		logic flush;
		logic kill;
		logic [1:0] code;
		logic [KLEN_W-1:0] k;
	} cell_ctl_t;

	function automatic base_dec_t decode_base(input logic [CHAR_W-1:0] ch);
		base_dec_t d;
		d.ok = 1'b1;
		d.code = CODE_A;
		case (ch)
			CHAR_A: d.code = CODE_A;
			CHAR_C: d.code = CODE_C;
			CHAR_G: d.code = CODE_G;
			CHAR_T: d.code = CODE_T;
			default: d.ok = 1'b0;
		endcase
		return d;
	endfunction

endpackage

@@ design/ckx_cell.sv @@
// One window cell: two bits of the forward and two bits of the reverse-complement window.
module ckx_cell #(
	parameter int IDX = 0
) (
	input  logic             clk,
	input  logic             arst_n,
	input  ckx_pkg::cell_ctl_t ctl,
	input  logic [1:0]       fwd_left,
	input  logic [1:0]       rev_right,
	output logic [1:0]       fwd_d,
	output logic [1:0]       rev_d,
	output logic [1:0]       fwd_q,
	output logic [1:0]       rev_q
);

	logic active;
	logic is_top;

	assign active = ckx_pkg::KLEN_W'(IDX) < ctl.k;
	assign is_top = ckx_pkg::KLEN_W'(IDX + 1) == ctl.k;

	always_comb begin
		fwd_d = fwd_q;
		rev_d = rev_q;
		if (ctl.load) begin
			if (ctl.kill || !active) begin
				fwd_d = 2'b00;
				rev_d = 2'b00;
			end else begin
				if (IDX == 0) begin
					fwd_d = ctl.code;
				end else begin
					fwd_d = ctl.flush ? 2'b00 : fwd_left;
				end
				if (is_top) begin
					rev_d = ~ctl.code;
				end else begin
					rev_d = ctl.flush ? 2'b00 : rev_right;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q <= 2'b00;
			rev_q <= 2'b00;
		end else begin
			fwd_q <= fwd_d;
			rev_q <= rev_d;
		end
	end

endmodule

@@ design/canonical_kmer_extractor_unit.sv @@
// Top level: cell chain for the rolling windows, run counter, canonical select and output register.
// A result is registered and presented in the cycle after the base that completes it is accepted.
// One base per cycle unless stalled; a valid base shifts both windows, an invalid one clears them.
// The output register takes a new result whenever it is empty or being drained.
// Reset clears the windows, run counter and output valid; k resets to 21, canonical mode to 0.
module canonical_kmer_extractor_unit #(
	parameter int MAX_K = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          base_valid,
	output logic                          base_stall,
	input  logic [ckx_pkg::CHAR_W-1:0]    base_char,
	input  logic [ckx_pkg::GROUP_W-1:0]   group_id,
	input  logic                          seq_start,
	output logic                          kmer_valid,
	input  logic                          kmer_stall,
	output logic [ckx_pkg::KEY_W-1:0]     kmer_key,
	output logic [ckx_pkg::GROUP_W-1:0]   group_out,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ckx_pkg::ADDR_W-1:0]    paddr,
	input  logic [ckx_pkg::DATA_W-1:0]    pwdata,
	output logic [ckx_pkg::DATA_W-1:0]    prdata,
	output logic                          pready
);

	localparam int RW = $clog2(MAX_K + 1);
	localparam int WW = 2 * MAX_K;

	logic [ckx_pkg::KLEN_W-1:0] kmer_length_q;
	logic                       canonical_mode_q;
	logic [ckx_pkg::KLEN_W-1:0] k_eff;
	logic                       wr_en;

	logic                       accept;
	ckx_pkg::base_dec_t         dec;
	ckx_pkg::cell_ctl_t         ctl;

	logic [1:0] fwd_d [MAX_K];
	logic [1:0] rev_d [MAX_K];
	logic [1:0] fwd_q [MAX_K];
	logic [1:0] rev_q [MAX_K];
	logic [WW-1:0] fwd_next;
	logic [WW-1:0] rev_next;
	logic [WW-1:0] fwd_win;

	logic [RW-1:0] run_q;
	logic [RW-1:0] run_base;
	logic [RW-1:0] run_d;
	logic          emit;
	logic [WW-1:0] key_sel;

	logic                        kmer_valid_q;
	logic [ckx_pkg::KEY_W-1:0]   kmer_key_q;
	logic [ckx_pkg::GROUP_W-1:0] group_out_q;

	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kmer_length_q <= ckx_pkg::KLEN_RESET;
			canonical_mode_q <= 1'b0;
		end else if (wr_en) begin
			case (ckx_pkg::reg_idx_t'(paddr[2]))
				ckx_pkg::REG_KMER_LENGTH: kmer_length_q <= pwdata[ckx_pkg::KLEN_W-1:0];
				ckx_pkg::REG_CANONICAL_MODE: canonical_mode_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (ckx_pkg::reg_idx_t'(paddr[2]))
			ckx_pkg::REG_KMER_LENGTH:
				prdata = ckx_pkg::DATA_W'(kmer_length_q);
			ckx_pkg::REG_CANONICAL_MODE:
				prdata = ckx_pkg::DATA_W'(canonical_mode_q);
			default: prdata = '0;
		endcase
	end

	always_comb begin
		if (kmer_length_q == '0) begin
			k_eff = ckx_pkg::KLEN_W'(1);
		end else if (kmer_length_q > ckx_pkg::KLEN_W'(MAX_K)) begin
			k_eff = ckx_pkg::KLEN_W'(MAX_K);
		end else begin
			k_eff = kmer_length_q;
		end
	end

	assign base_stall = kmer_valid_q && kmer_stall;
	assign accept = base_valid && !base_stall;
	assign dec = ckx_pkg::decode_base(base_char);

	assign ctl.load  = accept;
	assign ctl.flush = seq_start;
	assign ctl.kill  = !dec.ok;
	assign ctl.code  = dec.code;
	assign ctl.k     = k_eff;

	for (genvar i = 0; i < MAX_K; i++) begin : g_cell
		logic [1:0] left_in;
		logic [1:0] right_in;
		if (i == 0) begin : g_first
			assign left_in = dec.code;
		end else begin : g_mid
			assign left_in = fwd_q[i-1];
		end
		if (i == MAX_K - 1) begin : g_last
			assign right_in = 2'b00;
		end else begin : g_inner
			assign right_in = rev_q[i+1];
		end
		ckx_cell #(
			.IDX(i)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.fwd_left (left_in),
			.rev_right(right_in),
			.fwd_d    (fwd_d[i]),
			.rev_d    (rev_d[i]),
			.fwd_q    (fwd_q[i]),
			.rev_q    (rev_q[i])
		);
		assign fwd_next[2*i +: 2] = fwd_d[i];
		assign rev_next[2*i +: 2] = rev_d[i];
		assign fwd_win[2*i +: 2]  = fwd_q[i];
	end

	always_comb begin
		run_base = seq_start ? '0 : run_q;
		if (!dec.ok) begin
			run_d = '0;
		end else if (run_base == RW'(MAX_K)) begin
			run_d = run_base;
		end else begin
			run_d = run_base + RW'(1);
		end
	end

	assign emit = dec.ok && (7'(run_d) >= 7'(k_eff));
	assign key_sel = (canonical_mode_q && (rev_next < fwd_next)) ? rev_next : fwd_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= '0;
		end else if (accept) begin
			run_q <= run_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kmer_valid_q <= 1'b0;
		end else if (accept) begin
			kmer_valid_q <= emit;
		end else if (!kmer_stall) begin
			kmer_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && emit) begin
			kmer_key_q <= ckx_pkg::KEY_W'(key_sel);
			group_out_q <= group_id;
		end
	end

	assign kmer_valid = kmer_valid_q;
	assign kmer_key = kmer_key_q;
	assign group_out = group_out_q;

`ifndef ASSERT_OFF
	a_invalid_clears_run: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !dec.ok) |=> (run_q == '0))
		else $error("run counter not cleared by invalid base");

	a_run_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		7'(run_q) <= 7'(MAX_K))
		else $error("run counter beyond maximum k");

	a_forward_key: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && emit && !canonical_mode_q) |=> (kmer_key == ckx_pkg::KEY_W'(fwd_win)))
		else $error("forward key differs from window");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		base_stall |-> kmer_valid)
		else $error("input stalled with empty output register");

	a_result_from_accept: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(kmer_valid) |-> $past(accept))
		else $error("result appeared without an accepted transaction");
`endif

endmodule
